@@ src/ordered_value_list_defines.svh @@
// ----------------------------------------------------------------------------
// Ordered value list assertion macros
// Shared assertion shorthands, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_VALUE_LIST_DEFINES_SVH
`define ORDERED_VALUE_LIST_DEFINES_SVH

// Checks that a property holds at every rising clock edge out of reset.
`define OVL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is never true at a rising clock edge out of reset.
`define OVL_NEVER(label, cond, msg) \
  `OVL_ASSERT(label, !(cond), msg)

`endif

@@ src/ovl_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered value list package
// Sizes, operation codes and derived widths shared by the list logic.
// ----------------------------------------------------------------------------
package ovl_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned COUNT_OUT_W = 5;
  localparam int unsigned AW          = $clog2(DEPTH);
  localparam int unsigned CW          = $clog2(DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_FRONT  = 2'd0,
    CMD_BACK   = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

endpackage

@@ src/ovl_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ovl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/ordered_value_list.sv @@
// ----------------------------------------------------------------------------
// Ordered value list
// Holds an ordered sequence of signed values in a RAM and serves insert-front,
// insert-back, delete-first-match and search operations, one result each.
// ----------------------------------------------------------------------------
//   channel | signals                              | direction
//   in      | in_valid_i, in_stall_o, cmd_i,       | transfer into the block
//           | value_i                              |
//   out     | out_valid_o, out_stall_i, hit_o,     | transfer out of the block
//           | rejected_o, entry_count_o            |
//
// Insert-back and a rejected insert go straight to the finish state; search
// and delete scan from the first entry, insert-front shifts up from the last
// and then writes the head, as the sequencer walks the held entries one a cycle.
// Reset clears the entry count and the control state; the RAM needs no clearing pass.
// A new item is taken while an earlier result waits in the output register;
// the block then holds its finished result until the output register frees.
// ----------------------------------------------------------------------------
`include "ordered_value_list_defines.svh"

module ordered_value_list
  import ovl_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [CMD_W-1:0]              cmd_i,
  input  logic signed [DATA_W-1:0]      value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic                          rejected_o,
  output logic [COUNT_OUT_W-1:0]        entry_count_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PUT  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]               state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic                     rd_more_q, rd_more_d;
  logic                     pend_q, pend_d;
  logic                     out_valid_q, out_valid_d;
  cmd_e                     cmd_q, cmd_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  logic [AW-1:0]            rd_idx_q, rd_idx_d;
  logic [AW-1:0]            pend_idx_q, pend_idx_d;
  logic                     found_q, found_d;
  logic                     hit_q, hit_d;
  logic                     rej_q, rej_d;
  logic                     out_hit_q, out_rej_q;
  logic [COUNT_OUT_W-1:0]   out_count_q;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr;
  logic [DATA_W-1:0]        ram_wdata, ram_rdata;

  logic                     in_accept, out_load, full, empty, match;
  logic [AW-1:0]            last_idx, scan_end;

  ovl_ram #(
    .Width(DATA_W),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);
  assign last_idx   = AW'(count_q - CW'(1));
  assign scan_end   = (cmd_q == CMD_FRONT) ? '0 : last_idx;
  assign match      = pend_q && (ram_rdata == value_q);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_more_d  = rd_more_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    rd_idx_d   = rd_idx_q;
    cmd_d      = cmd_q;
    value_d    = value_q;
    found_d    = found_q;
    hit_d      = hit_q;
    rej_d      = rej_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = ram_rdata;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_d   = cmd_e'(cmd_i);
          value_d = value_i;
          hit_d   = 1'b0;
          rej_d   = 1'b0;
          found_d = 1'b0;
          unique case (cmd_e'(cmd_i)) inside
            CMD_FRONT: begin
              if (full) begin
                rej_d   = 1'b1;
                state_d = S_FIN;
              end else if (empty) begin
                state_d = S_PUT;
              end else begin
                rd_idx_d  = last_idx;
                rd_more_d = 1'b1;
                state_d   = S_SCAN;
              end
            end
            CMD_BACK: begin
              if (full) begin
                rej_d = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(count_q);
                ram_wdata = value_i;
                count_d   = count_q + CW'(1);
              end
              state_d = S_FIN;
            end
            CMD_DELETE, CMD_SEARCH: begin
              if (empty) begin
                state_d = S_FIN;
              end else begin
                rd_idx_d  = '0;
                rd_more_d = 1'b1;
                state_d   = S_SCAN;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (rd_more_q) begin
          ram_re     = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = rd_idx_q;
          if (rd_idx_q == scan_end) begin
            rd_more_d = 1'b0;
          end else if (cmd_q == CMD_FRONT) begin
            rd_idx_d = rd_idx_q - AW'(1);
          end else begin
            rd_idx_d = rd_idx_q + AW'(1);
          end
        end
        if (pend_q) begin
          if (cmd_q == CMD_FRONT) begin
            ram_we    = 1'b1;
            ram_waddr = pend_idx_q + AW'(1);
          end else if (cmd_q == CMD_DELETE && found_q) begin
            ram_we    = 1'b1;
            ram_waddr = pend_idx_q - AW'(1);
          end
          if (match) begin
            found_d = 1'b1;
          end
          if (!rd_more_q) begin
            if (cmd_q == CMD_FRONT) begin
              state_d = S_PUT;
            end else begin
              hit_d = found_q || match;
              if (cmd_q == CMD_DELETE && (found_q || match)) begin
                count_d = count_q - CW'(1);
              end
              state_d = S_FIN;
            end
          end
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = value_q;
        count_d   = count_q + CW'(1);
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_more_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_more_q   <= rd_more_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    value_q    <= value_d;
    rd_idx_q   <= rd_idx_d;
    pend_idx_q <= pend_idx_d;
    found_q    <= found_d;
    hit_q      <= hit_d;
    rej_q      <= rej_d;
    if (out_load) begin
      out_hit_q   <= hit_q;
      out_rej_q   <= rej_q;
      out_count_q <= COUNT_OUT_W'(count_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign rejected_o    = out_rej_q;
  assign entry_count_o = out_count_q;

  `OVL_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "entry count exceeds capacity")
  `OVL_ASSERT(a_out_from_fin, $rose(out_valid_q) |-> $past(state_q) == S_FIN,
              "result appeared without a finished item")
  `OVL_ASSERT(a_scan_in_range, (state_q == S_SCAN && rd_more_q) |-> CW'(rd_idx_q) < count_q,
              "scan read beyond the held entries")
  `OVL_NEVER(a_no_write_in_fin, ram_we && state_q == S_FIN, "RAM written while finishing")
  `OVL_NEVER(a_flags_exclusive, out_valid_q && out_hit_q && out_rej_q,
             "hit and rejected both set")

endmodule
